// ===== rtl/core/numeric_literal_classifier_assert.svh =====
// assertion macros for the numeric literal classifier checker
// no dependencies; expects i_clk and i_rst_n in the including scope
`ifndef NUMERIC_LITERAL_CLASSIFIER_ASSERT_SVH
`define NUMERIC_LITERAL_CLASSIFIER_ASSERT_SVH

// same-cycle implication, reset masked
`define NLC_ASSERT_IMP(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("nlc assertion failed");

// next-cycle implication, reset masked
`define NLC_ASSERT_NXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("nlc assertion failed");

`endif

// ===== rtl/core/nlc_pkg.sv =====
// types and next-phase functions for the numeric literal classifier
// no dependencies; used by nlc_scan and numeric_literal_classifier
package nlc_pkg;

    localparam int CharW = 8;

    typedef enum logic [4:0] {
        I_START  = 5'd0,
        I_SIGN   = 5'd1,
        I_ZERO   = 5'd2,
        I_MARK   = 5'd3,
        I_DIGITS = 5'd4,
        S_U      = 5'd5,
        S_UL     = 5'd6,
        S_ULL    = 5'd7,
        S_L      = 5'd8,
        S_LU     = 5'd9,
        S_LL     = 5'd10,
        S_LLU    = 5'd11,
        S_I      = 5'd12,
        S_I6     = 5'd13,
        S_I64    = 5'd14,
        I_REJECT = 5'd15
    } t_int_phase;

    typedef enum logic [1:0] {
        K_DEC = 2'd0,
        K_OCT = 2'd1,
        K_HEX = 2'd2,
        K_BIN = 2'd3
    } t_int_kind;

    typedef enum logic [3:0] {
        D_START  = 4'd0,
        D_SIGN   = 4'd1,
        D_INT    = 4'd2,
        D_LEAD   = 4'd3,
        D_TRAIL  = 4'd4,
        D_FRAC   = 4'd5,
        D_E      = 4'd6,
        D_ESIGN  = 4'd7,
        D_EXP    = 4'd8,
        D_SUF_F  = 4'd9,
        D_SUF_L  = 4'd10,
        D_REJECT = 4'd11
    } t_dec_phase;

    typedef enum logic [3:0] {
        H_START  = 4'd0,
        H_SIGN   = 4'd1,
        H_ZERO   = 4'd2,
        H_WHOLE1 = 4'd3,
        H_WHOLE  = 4'd4,
        H_FRAC   = 4'd5,
        H_EXP1   = 4'd6,
        H_EXP    = 4'd7,
        H_ACCEPT = 4'd8,
        H_REJECT = 4'd9
    } t_hex_phase;

    // first member sits in the top bit, so dec_int lands in bit 0
    typedef struct packed {
        logic any_float;
        logic any_int;
        logic hex_float;
        logic dec_float;
        logic bin_int;
        logic hex_int;
        logic oct_int;
        logic dec_int;
    } t_verdict;

    function automatic logic is_dig(input logic [CharW-1:0] c);
        return c >= "0" && c <= "9";
    endfunction

    function automatic logic is_xdig(input logic [CharW-1:0] c);
        return is_dig(c) || (c >= "a" && c <= "f") || (c >= "A" && c <= "F");
    endfunction

    function automatic logic is_sign(input logic [CharW-1:0] c);
        return c == "+" || c == "-";
    endfunction

    function automatic logic is_u(input logic [CharW-1:0] c);
        return c == "u" || c == "U";
    endfunction

    function automatic logic is_l(input logic [CharW-1:0] c);
        return c == "l" || c == "L";
    endfunction

    function automatic logic kind_digit(input t_int_kind k, input logic [CharW-1:0] c);
        logic d;
        unique case (k)
            K_OCT:   d = c >= "0" && c <= "7";
            K_HEX:   d = is_xdig(c);
            K_BIN:   d = c == "0" || c == "1";
            K_DEC:   d = is_dig(c);
            default: d = 1'b0;
        endcase
        return d;
    endfunction

    function automatic t_int_phase suffix_step(input t_int_phase s, input logic [CharW-1:0] c);
        t_int_phase n;
        n = I_REJECT;
        unique case (s)
            I_DIGITS: begin
                if (is_u(c))        n = S_U;
                else if (is_l(c))   n = S_L;
                else if (c == "i")  n = S_I;
            end
            S_U:  if (is_l(c)) n = S_UL;
            S_UL: if (is_l(c)) n = S_ULL;
            S_L: begin
                if (is_u(c))      n = S_LU;
                else if (is_l(c)) n = S_LL;
            end
            S_LL: if (is_u(c))   n = S_LLU;
            S_I:  if (c == "6")  n = S_I6;
            S_I6: if (c == "4")  n = S_I64;
            default: n = I_REJECT;
        endcase
        return n;
    endfunction

    // first character after an optional sign
    function automatic t_int_phase int_lead(input t_int_kind k, input logic [CharW-1:0] c);
        t_int_phase n;
        if (k == K_DEC) n = is_dig(c) ? I_DIGITS : I_REJECT;
        else            n = (c == "0") ? I_ZERO : I_REJECT;
        return n;
    endfunction

    function automatic t_int_phase int_step(input t_int_phase s, input logic [CharW-1:0] c,
                                            input t_int_kind k);
        t_int_phase n;
        logic       dig;
        dig = kind_digit(k, c);
        n   = I_REJECT;
        unique case (s)
            I_START: n = is_sign(c) ? I_SIGN : int_lead(k, c);
            I_SIGN:  n = int_lead(k, c);
            I_ZERO: begin
                unique case (k)
                    K_OCT:   n = dig ? I_DIGITS : I_REJECT;
                    K_HEX:   n = (c == "x" || c == "X") ? I_MARK : I_REJECT;
                    K_BIN:   n = (c == "b" || c == "B") ? I_MARK : I_REJECT;
                    default: n = I_REJECT;
                endcase
            end
            I_MARK:   n = dig ? I_DIGITS : I_REJECT;
            I_DIGITS: n = dig ? I_DIGITS : suffix_step(s, c);
            default:  n = suffix_step(s, c);
        endcase
        return n;
    endfunction

    function automatic logic int_ok(input t_int_phase s);
        return s == I_DIGITS || (s >= S_U && s <= S_LLU) || s == S_I64;
    endfunction

    function automatic t_dec_phase decf_step(input t_dec_phase s, input logic [CharW-1:0] c);
        t_dec_phase n;
        logic       e;
        logic       f;
        e = c == "e" || c == "E";
        f = c == "f" || c == "F";
        n = D_REJECT;
        unique case (s)
            D_START: begin
                if (is_sign(c))     n = D_SIGN;
                else if (c == ".")  n = D_LEAD;
                else if (is_dig(c)) n = D_INT;
            end
            D_SIGN: begin
                if (c == ".")       n = D_LEAD;
                else if (is_dig(c)) n = D_INT;
                else if (e)         n = D_E;
            end
            D_LEAD: begin
                if (is_dig(c)) n = D_FRAC;
                else if (e)    n = D_E;
            end
            D_INT: begin
                if (e)              n = D_E;
                else if (c == ".")  n = D_TRAIL;
                else if (is_dig(c)) n = D_INT;
            end
            D_TRAIL, D_FRAC: begin
                if (e)              n = D_E;
                else if (f)         n = D_SUF_F;
                else if (is_l(c))   n = D_SUF_L;
                else if (is_dig(c)) n = D_FRAC;
            end
            D_E: begin
                if (is_sign(c))     n = D_ESIGN;
                else if (is_dig(c)) n = D_EXP;
            end
            D_ESIGN: if (is_dig(c)) n = D_EXP;
            D_EXP: begin
                if (f)              n = D_SUF_F;
                else if (is_l(c))   n = D_SUF_L;
                else if (is_dig(c)) n = D_EXP;
            end
            default: n = D_REJECT;
        endcase
        return n;
    endfunction

    function automatic logic decf_ok(input t_dec_phase s);
        return s == D_FRAC || s == D_EXP || s == D_TRAIL || s == D_SUF_F || s == D_SUF_L;
    endfunction

    function automatic t_hex_phase hexf_step(input t_hex_phase s, input logic [CharW-1:0] c);
        t_hex_phase n;
        logic       p;
        p = c == "p" || c == "P";
        n = H_REJECT;
        unique case (s)
            H_START: begin
                if (is_sign(c))    n = H_SIGN;
                else if (c == "0") n = H_ZERO;
            end
            H_SIGN:   if (c == "0") n = H_ZERO;
            H_ZERO:   if (c == "x" || c == "X") n = H_WHOLE1;
            H_WHOLE1: if (is_xdig(c)) n = H_WHOLE;
            H_WHOLE: begin
                if (is_xdig(c))    n = H_WHOLE;
                else if (c == ".") n = H_FRAC;
                else if (p)        n = H_EXP1;
            end
            H_FRAC: begin
                if (is_xdig(c)) n = H_FRAC;
                else if (p)     n = H_EXP1;
            end
            // hex digits and a sign both count as exponent digits here
            H_EXP1: if (is_xdig(c) || is_sign(c)) n = H_EXP;
            H_EXP: begin
                if (is_xdig(c))                          n = H_EXP;
                else if (is_l(c) || c == "f" || c == "F") n = H_ACCEPT;
            end
            H_ACCEPT: n = H_ACCEPT;
            default:  n = H_REJECT;
        endcase
        return n;
    endfunction

endpackage

// ===== rtl/core/nlc_scan.sv =====
// six literal recognisers with their phase registers
// depends on nlc_pkg
module nlc_scan
    import nlc_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_step,
    input  logic [CharW-1:0] i_char,
    input  logic             i_last,
    output t_verdict         o_verdict
);

    t_int_phase r_dec, r_oct, r_hex, r_bin;
    t_int_phase n_dec, n_oct, n_hex, n_bin;
    t_dec_phase r_decf, n_decf;
    t_hex_phase r_hexf, n_hexf;

    always_comb begin
        n_dec  = int_step(r_dec, i_char, K_DEC);
        n_oct  = int_step(r_oct, i_char, K_OCT);
        n_hex  = int_step(r_hex, i_char, K_HEX);
        n_bin  = int_step(r_bin, i_char, K_BIN);
        n_decf = decf_step(r_decf, i_char);
        n_hexf = hexf_step(r_hexf, i_char);
    end

    // verdict taken from the phases after this character
    always_comb begin
        o_verdict.dec_int   = int_ok(n_dec);
        o_verdict.oct_int   = int_ok(n_oct);
        o_verdict.hex_int   = int_ok(n_hex);
        o_verdict.bin_int   = int_ok(n_bin);
        o_verdict.dec_float = decf_ok(n_decf);
        o_verdict.hex_float = (n_hexf == H_EXP) || (n_hexf == H_ACCEPT);
        o_verdict.any_int   = o_verdict.dec_int | o_verdict.oct_int
                            | o_verdict.hex_int | o_verdict.bin_int;
        o_verdict.any_float = o_verdict.dec_float | o_verdict.hex_float;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || (i_step && i_last)) begin
            r_dec  <= I_START;
            r_oct  <= I_START;
            r_hex  <= I_START;
            r_bin  <= I_START;
            r_decf <= D_START;
            r_hexf <= H_START;
        end else if (i_step) begin
            r_dec  <= n_dec;
            r_oct  <= n_oct;
            r_hex  <= n_hex;
            r_bin  <= n_bin;
            r_decf <= n_decf;
            r_hexf <= n_hexf;
        end
    end

endmodule

// ===== rtl/core/numeric_literal_classifier.sv =====
// Numeric literal classifier: takes one character beat per clock and, on the
// beat flagged tlast, emits one verdict beat for the whole token. Throughput is
// one character per cycle, set by the recogniser phase registers which update on
// every accepted beat; the verdict beat appears in the cycle after the closing
// character is accepted and is held in an output register, so input keeps
// flowing unless a verdict is waiting and the downstream side is not ready.
// Depends on nlc_pkg and nlc_scan.
module numeric_literal_classifier
    import nlc_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_s_tvalid,
    output logic             o_s_tready,
    input  logic [CharW-1:0] i_s_tdata,   // [7:0] character
    input  logic             i_s_tlast,   // last
    output logic             o_m_tvalid,
    input  logic             i_m_tready,
    output logic [7:0]       o_m_tdata    // dec_int, oct_int, hex_int, bin_int,
                                          // dec_float, hex_float, any_int, any_float
);

    logic     w_step;
    t_verdict w_verdict;
    logic     r_out_valid;
    t_verdict r_out_data;

    assign o_s_tready = !r_out_valid || i_m_tready;
    assign w_step     = i_s_tvalid && o_s_tready;

    nlc_scan u_scan (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_step    (w_step),
        .i_char    (i_s_tdata),
        .i_last    (i_s_tlast),
        .o_verdict (w_verdict)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_step && i_s_tlast) begin
            r_out_valid <= 1'b1;
        end else if (i_m_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    // payload only loads on a closing beat
    always_ff @(posedge i_clk) begin
        if (w_step && i_s_tlast) begin
            r_out_data <= w_verdict;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = r_out_data;

endmodule

// ===== rtl/core/nlc_checker.sv =====
// port-level checks for the numeric literal classifier, bound to the top level
// depends on numeric_literal_classifier_assert.svh
`include "numeric_literal_classifier_assert.svh"

module nlc_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_s_tvalid,
    input logic       o_s_tready,
    input logic [7:0] i_s_tdata,
    input logic       i_s_tlast,
    input logic       o_m_tvalid,
    input logic       i_m_tready,
    input logic [7:0] o_m_tdata
);

    logic w_close;
    logic w_stall;

    assign w_close = i_s_tvalid && o_s_tready && i_s_tlast;
    assign w_stall = o_m_tvalid && !i_m_tready;

    // a waiting verdict holds its bits
    `NLC_ASSERT_NXT(a_hold, w_stall, o_m_tvalid && $stable(o_m_tdata))
    // a closing beat always yields a verdict beat
    `NLC_ASSERT_NXT(a_close_out, w_close, o_m_tvalid)
    // no verdict beat without a closing beat or a held one
    `NLC_ASSERT_NXT(a_no_spurious, !w_close && !w_stall, !o_m_tvalid)
    // a stalled verdict blocks new characters
    `NLC_ASSERT_IMP(a_backpressure, w_stall, !o_s_tready)

endmodule

bind numeric_literal_classifier nlc_checker u_nlc_checker (.*);

// ===== dv/testbench.sv =====
`timescale 1ns / 1ps
// self-checking bench for numeric_literal_classifier: tokens go in one character per beat,
// and each verdict beat is checked against a local model of the six recognisers
// depends on nlc_pkg for the phase enums, the integer kinds and the verdict layout
module testbench;
    import nlc_pkg::*;

    localparam int HALF_PERIOD  = 5;
    localparam int RESET_CYCLES = 5;
    localparam int ITEM_TARGET  = 1700;
    localparam int IDLE_LIMIT   = 5000;
    localparam int DRAIN_CYCLES = 8;
    localparam int REPORT_MAX   = 10;

    localparam string DEC_SET   = "0123456789";
    localparam string OCT_SET   = "01234567";
    localparam string BIN_SET   = "01";
    localparam string HEX_SET   = "0123456789abcdefABCDEF";
    localparam string NOISE_SET = "0123456789aAbBeEfFxXpPuUlLi64+-.";
    localparam string FLT_SUF   = "fFlL";

    typedef struct packed {
        logic [CharW-1:0] ch;
        logic             closes;
    } t_char_beat;

    typedef enum int {RX_OPEN, RX_COIN, RX_SLOW, RX_MOSTLY} t_rx_mode;

    string int_suffix[24] = '{"", "", "", "", "u", "U", "l", "L", "ul", "Ul", "uL", "lu",
                              "LU", "ll", "LL", "lL", "ull", "ULL", "llu", "LLU", "i64",
                              "i6", "I64", "lul"};
    string verdict_field[8] = '{"dec_int", "oct_int", "hex_int", "bin_int",
                                "dec_float", "hex_float", "any_int", "any_float"};

    logic             i_clk      = 1'b0;
    logic             i_rst_n    = 1'b0;
    logic             i_s_tvalid = 1'b0;
    logic [CharW-1:0] i_s_tdata  = '0;
    logic             i_s_tlast  = 1'b0;
    logic             i_m_tready = 1'b0;
    logic             o_s_tready;
    logic             o_m_tvalid;
    logic [7:0]       o_m_tdata;

    numeric_literal_classifier uut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),   // [7:0] character
        .i_s_tlast  (i_s_tlast),   // last
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata)    // dec_int, oct_int, hex_int, bin_int,
                                   // dec_float, hex_float, any_int, any_float
    );

    always #HALF_PERIOD i_clk = ~i_clk;

    t_char_beat       char_backlog[$];
    t_verdict         verdicts_due[$];
    logic [CharW-1:0] tok[$];
    int               tokens_queued = 0;
    int               verdicts_seen = 0;
    int               mismatches    = 0;

    // scan state of the local model
    t_int_phase dec_ph, oct_ph, hex_ph, bin_ph;
    t_dec_phase dflt_ph;
    t_hex_phase hflt_ph;

    function automatic logic is_decimal(input logic [CharW-1:0] c);
        return c >= "0" && c <= "9";
    endfunction

    function automatic logic is_hexdigit(input logic [CharW-1:0] c);
        return is_decimal(c) || (c >= "a" && c <= "f") || (c >= "A" && c <= "F");
    endfunction

    function automatic logic is_plusminus(input logic [CharW-1:0] c);
        return c == "+" || c == "-";
    endfunction

    function automatic logic is_uletter(input logic [CharW-1:0] c);
        return c == "u" || c == "U";
    endfunction

    function automatic logic is_lletter(input logic [CharW-1:0] c);
        return c == "l" || c == "L";
    endfunction

    function automatic logic radix_digit(input t_int_kind k, input logic [CharW-1:0] c);
        logic d;
        case (k)
            K_OCT:   d = c >= "0" && c <= "7";
            K_HEX:   d = is_hexdigit(c);
            K_BIN:   d = c == "0" || c == "1";
            default: d = is_decimal(c);
        endcase
        return d;
    endfunction

    function automatic t_int_phase suffix_next(input t_int_phase s, input logic [CharW-1:0] c);
        t_int_phase n;
        n = I_REJECT;
        case (s)
            I_DIGITS: begin
                if (is_uletter(c))      n = S_U;
                else if (is_lletter(c)) n = S_L;
                else if (c == "i")      n = S_I;
            end
            S_U:  if (is_lletter(c)) n = S_UL;
            S_UL: if (is_lletter(c)) n = S_ULL;
            S_L: begin
                if (is_uletter(c))      n = S_LU;
                else if (is_lletter(c)) n = S_LL;
            end
            S_LL: if (is_uletter(c)) n = S_LLU;
            S_I:  if (c == "6") n = S_I6;
            S_I6: if (c == "4") n = S_I64;
            default: n = I_REJECT;
        endcase
        return n;
    endfunction

    function automatic t_int_phase int_next(input t_int_phase s, input logic [CharW-1:0] c,
                                            input t_int_kind k);
        t_int_phase n;
        case (s)
            I_START, I_SIGN: begin
                if (s == I_START && is_plusminus(c)) n = I_SIGN;
                else if (k == K_DEC) n = is_decimal(c) ? I_DIGITS : I_REJECT;
                else                 n = (c == "0") ? I_ZERO : I_REJECT;
            end
            I_ZERO: begin
                case (k)
                    K_OCT:   n = radix_digit(k, c) ? I_DIGITS : I_REJECT;
                    K_HEX:   n = (c == "x" || c == "X") ? I_MARK : I_REJECT;
                    K_BIN:   n = (c == "b" || c == "B") ? I_MARK : I_REJECT;
                    default: n = I_REJECT;
                endcase
            end
            I_MARK:   n = radix_digit(k, c) ? I_DIGITS : I_REJECT;
            I_DIGITS: n = radix_digit(k, c) ? I_DIGITS : suffix_next(s, c);
            default:  n = suffix_next(s, c);
        endcase
        return n;
    endfunction

    function automatic logic int_accepts(input t_int_phase s);
        return s == I_DIGITS || (s >= S_U && s <= S_LLU) || s == S_I64;
    endfunction

    function automatic t_dec_phase decfloat_next(input t_dec_phase s, input logic [CharW-1:0] c);
        t_dec_phase n;
        logic       e;
        logic       f;
        e = c == "e" || c == "E";
        f = c == "f" || c == "F";
        n = D_REJECT;
        case (s)
            D_START: begin
                if (is_plusminus(c))    n = D_SIGN;
                else if (c == ".")      n = D_LEAD;
                else if (is_decimal(c)) n = D_INT;
            end
            D_SIGN: begin
                if (c == ".")           n = D_LEAD;
                else if (is_decimal(c)) n = D_INT;
                else if (e)             n = D_E;
            end
            D_LEAD: begin
                if (is_decimal(c)) n = D_FRAC;
                else if (e)        n = D_E;
            end
            D_INT: begin
                if (e)                  n = D_E;
                else if (c == ".")      n = D_TRAIL;
                else if (is_decimal(c)) n = D_INT;
            end
            D_TRAIL, D_FRAC: begin
                if (e)                  n = D_E;
                else if (f)             n = D_SUF_F;
                else if (is_lletter(c)) n = D_SUF_L;
                else if (is_decimal(c)) n = D_FRAC;
            end
            D_E: begin
                if (is_plusminus(c))    n = D_ESIGN;
                else if (is_decimal(c)) n = D_EXP;
            end
            D_ESIGN: if (is_decimal(c)) n = D_EXP;
            D_EXP: begin
                if (f)                  n = D_SUF_F;
                else if (is_lletter(c)) n = D_SUF_L;
                else if (is_decimal(c)) n = D_EXP;
            end
            // anything after a suffix rejects
            default: n = D_REJECT;
        endcase
        return n;
    endfunction

    function automatic t_hex_phase hexfloat_next(input t_hex_phase s, input logic [CharW-1:0] c);
        t_hex_phase n;
        logic       p;
        p = c == "p" || c == "P";
        n = H_REJECT;
        case (s)
            H_START: begin
                if (is_plusminus(c)) n = H_SIGN;
                else if (c == "0")   n = H_ZERO;
            end
            H_SIGN:   if (c == "0") n = H_ZERO;
            H_ZERO:   if (c == "x" || c == "X") n = H_WHOLE1;
            H_WHOLE1: if (is_hexdigit(c)) n = H_WHOLE;
            H_WHOLE: begin
                if (is_hexdigit(c)) n = H_WHOLE;
                else if (c == ".")  n = H_FRAC;
                else if (p)         n = H_EXP1;
            end
            H_FRAC: begin
                if (is_hexdigit(c)) n = H_FRAC;
                else if (p)         n = H_EXP1;
            end
            // a sign straight after p already counts as an exponent digit
            H_EXP1: if (is_hexdigit(c) || is_plusminus(c)) n = H_EXP;
            H_EXP: begin
                if (is_hexdigit(c))                            n = H_EXP;
                else if (is_lletter(c) || c == "f" || c == "F") n = H_ACCEPT;
            end
            // once the suffix is seen, the rest of the token is ignored
            H_ACCEPT: n = H_ACCEPT;
            default:  n = H_REJECT;
        endcase
        return n;
    endfunction

    task automatic restart_scan();
        dec_ph  = I_START;
        oct_ph  = I_START;
        hex_ph  = I_START;
        bin_ph  = I_START;
        dflt_ph = D_START;
        hflt_ph = H_START;
    endtask

    task automatic take_char(input logic [CharW-1:0] c, input logic closes);
        t_verdict v;
        dec_ph  = int_next(dec_ph, c, K_DEC);
        oct_ph  = int_next(oct_ph, c, K_OCT);
        hex_ph  = int_next(hex_ph, c, K_HEX);
        bin_ph  = int_next(bin_ph, c, K_BIN);
        dflt_ph = decfloat_next(dflt_ph, c);
        hflt_ph = hexfloat_next(hflt_ph, c);
        if (closes) begin
            v.dec_int   = int_accepts(dec_ph);
            v.oct_int   = int_accepts(oct_ph);
            v.hex_int   = int_accepts(hex_ph);
            v.bin_int   = int_accepts(bin_ph);
            v.dec_float = dflt_ph == D_FRAC || dflt_ph == D_EXP || dflt_ph == D_TRAIL ||
                          dflt_ph == D_SUF_F || dflt_ph == D_SUF_L;
            v.hex_float = hflt_ph == H_EXP || hflt_ph == H_ACCEPT;
            v.any_int   = v.dec_int | v.oct_int | v.hex_int | v.bin_int;
            v.any_float = v.dec_float | v.hex_float;
            verdicts_due.push_back(v);
            restart_scan();
        end
    endtask

    // token assembly
    task automatic put_char(input logic [CharW-1:0] c);
        tok.push_back(c);
    endtask

    task automatic put_text(input string s);
        for (int i = 0; i < s.len(); i++) tok.push_back(s[i]);
    endtask

    task automatic put_digits(input int n, input string set);
        for (int i = 0; i < n; i++) tok.push_back(set[$urandom_range(0, set.len() - 1)]);
    endtask

    task automatic maybe_sign();
        if ($urandom_range(0, 3) == 0) put_char($urandom_range(0, 1) ? "+" : "-");
    endtask

    task automatic queue_token();
        t_char_beat b;
        for (int i = 0; i < tok.size(); i++) begin
            b.ch     = tok[i];
            b.closes = (i == tok.size() - 1);
            char_backlog.push_back(b);
        end
        tokens_queued++;
        tok.delete();
    endtask

    task automatic directed_token(input string s);
        put_text(s);
        queue_token();
    endtask

    task automatic make_token();
        int shape;
        int n;
        shape = $urandom_range(0, 9);
        case (shape)
            0, 1: begin
                maybe_sign();
                put_digits($urandom_range(1, 5), DEC_SET);
                put_text(int_suffix[$urandom_range(0, 23)]);
            end
            2: begin
                maybe_sign();
                put_char("0");
                put_digits($urandom_range(0, 4), OCT_SET);
                put_text(int_suffix[$urandom_range(0, 23)]);
            end
            3: begin
                maybe_sign();
                put_char("0");
                put_char($urandom_range(0, 1) ? "x" : "X");
                put_digits($urandom_range(0, 5), HEX_SET);
                put_text(int_suffix[$urandom_range(0, 23)]);
            end
            4: begin
                maybe_sign();
                put_char("0");
                put_char($urandom_range(0, 1) ? "b" : "B");
                put_digits($urandom_range(0, 6), BIN_SET);
                put_text(int_suffix[$urandom_range(0, 23)]);
            end
            5, 6: begin
                maybe_sign();
                put_digits($urandom_range(0, 3), DEC_SET);
                if ($urandom_range(0, 2) != 0) put_char(".");
                put_digits($urandom_range(0, 3), DEC_SET);
                if ($urandom_range(0, 1) == 0) begin
                    put_char($urandom_range(0, 1) ? "e" : "E");
                    maybe_sign();
                    put_digits($urandom_range(0, 2), DEC_SET);
                end
                if ($urandom_range(0, 2) == 0) put_digits(1, FLT_SUF);
            end
            7: begin
                maybe_sign();
                put_char("0");
                put_char($urandom_range(0, 1) ? "x" : "X");
                put_digits($urandom_range(0, 3), HEX_SET);
                if ($urandom_range(0, 1) == 0) begin
                    put_char(".");
                    put_digits($urandom_range(0, 3), HEX_SET);
                end
                if ($urandom_range(0, 4) != 0) begin
                    put_char($urandom_range(0, 1) ? "p" : "P");
                    maybe_sign();
                    put_digits($urandom_range(0, 3), HEX_SET);
                    if ($urandom_range(0, 1) == 0) put_digits(1, FLT_SUF);
                    if ($urandom_range(0, 3) == 0) put_digits($urandom_range(1, 3), NOISE_SET);
                end
            end
            8: put_digits($urandom_range(1, 6), NOISE_SET);
            default: begin
                n = $urandom_range(1, 4);
                for (int i = 0; i < n; i++) put_char(8'($urandom_range(0, 255)));
            end
        endcase
        // occasionally spoil one character of the token
        if (tok.size() > 0 && $urandom_range(0, 7) == 0) begin
            n = $urandom_range(0, tok.size() - 1);
            if ($urandom_range(0, 3) == 0) tok[n] = 8'($urandom_range(0, 255));
            else tok[n] = NOISE_SET[$urandom_range(0, NOISE_SET.len() - 1)];
        end
        if (tok.size() == 0) put_digits(1, DEC_SET);
        queue_token();
    endtask

    // character driver: bursts of beats with random gaps between them
    int burst_left = 0;
    int gap_left   = 0;

    always @(posedge i_clk) begin
        t_char_beat nxt;
        if (!i_rst_n) begin
            i_s_tvalid <= 1'b0;
            restart_scan();
        end else begin
            if (i_s_tvalid && o_s_tready) take_char(i_s_tdata, i_s_tlast);
            if (!i_s_tvalid || o_s_tready) begin
                if (gap_left > 0) begin
                    gap_left--;
                    i_s_tvalid <= 1'b0;
                end else if (char_backlog.size() > 0) begin
                    nxt = char_backlog.pop_front();
                    i_s_tdata  <= nxt.ch;
                    i_s_tlast  <= nxt.closes;
                    i_s_tvalid <= 1'b1;
                    if (burst_left > 0) begin
                        burst_left--;
                    end else begin
                        burst_left = $urandom_range(0, 40);
                        gap_left   = $urandom_range(0, 1) ? 0 : $urandom_range(1, 8);
                    end
                end else begin
                    i_s_tvalid <= 1'b0;
                end
            end
        end
    end

    // verdict side back-pressure, switching between a few stall patterns
    t_rx_mode rx_mode = RX_OPEN;
    int       rx_hold = 0;
    int       rx_tick = 0;

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_m_tready <= 1'b0;
        end else begin
            if (rx_hold == 0) begin
                rx_mode = t_rx_mode'($urandom_range(0, 3));
                rx_hold = $urandom_range(16, 160);
            end else begin
                rx_hold--;
            end
            rx_tick++;
            case (rx_mode)
                RX_OPEN:  i_m_tready <= 1'b1;
                RX_COIN:  i_m_tready <= 1'($urandom_range(0, 1));
                RX_SLOW:  i_m_tready <= (rx_tick % 5 == 0);
                default:  i_m_tready <= ($urandom_range(0, 7) != 0);
            endcase
        end
    end

    // verdict monitor
    always @(posedge i_clk) begin
        t_verdict want;
        t_verdict got;
        if (i_rst_n && o_m_tvalid && i_m_tready) begin
            got = t_verdict'(o_m_tdata);
            verdicts_seen++;
            if (verdicts_due.size() == 0) begin
                if (mismatches < REPORT_MAX)
                    $display("verdict beat %0d not expected: got %b", verdicts_seen, o_m_tdata);
                mismatches++;
            end else begin
                want = verdicts_due.pop_front();
                for (int b = 0; b < 8; b++) begin
                    if (want[b] !== got[b]) begin
                        if (mismatches < REPORT_MAX)
                            $display("verdict beat %0d %s: expected %b, got %b",
                                     verdicts_seen, verdict_field[b], want[b], got[b]);
                        mismatches++;
                    end
                end
            end
        end
    end

    // watchdog on cycles with no beat moving on either side
    int idle_cycles = 0;

    always @(posedge i_clk) begin
        if (!i_rst_n || (i_s_tvalid && o_s_tready) || (o_m_tvalid && i_m_tready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles == IDLE_LIMIT) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin
        put_char(8'hFF);              // code above 127 on its own
        queue_token();
        directed_token("0");
        directed_token("07u");
        directed_token("0b1L");
        directed_token("+5i64");
        directed_token("1.f1");       // character after a float suffix
        directed_token("0xAp-lz");    // signed hex exponent, suffix then trailing junk
        directed_token("0x1.g");      // stray character in the hex fraction
        while (char_backlog.size() < ITEM_TARGET) make_token();

        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (verdicts_seen < tokens_queued) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (mismatches == 0 && verdicts_due.size() == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule
